FILE: src/fsfe_pkg.sv
`timescale 1ns / 1ps
package fsfe_pkg;

  // Signed working coordinate, wide enough for every corner and edge sum.
  localparam int CoordW = 14;
  typedef logic signed [CoordW-1:0] coord_t;

  // Integer square root operand and result widths (radius is 10 bits).
  localparam int SqInW  = 20;
  localparam int SqOutW = 10;

  typedef enum logic [2:0] {
    CMD_CLEAR         = 3'd0,
    CMD_SET_PIXEL     = 3'd1,
    CMD_GET_PIXEL     = 3'd2,
    CMD_FILL_RECT     = 3'd3,
    CMD_OUTLINE_RECT  = 3'd4,
    CMD_FILL_ROUND    = 3'd5,
    CMD_OUTLINE_ROUND = 3'd6,
    CMD_THICK_ROUND   = 3'd7
  } cmd_t;

  // A classified command as it waits in the queue.
  typedef struct packed {
    logic        is_read;
    logic        outline;
    logic        thick;
    coord_t      x;
    coord_t      y;
    coord_t      w;
    coord_t      h;
    coord_t      r;
    coord_t      t;
    logic [7:0]  color;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_START,
    B_MID,
    B_SQ,
    B_SQWAIT,
    B_ROW,
    B_BOXSET,
    B_BOXRUN,
    B_END,
    B_READ,
    B_RDOUT,
    B_DONE
  } back_state_t;

endpackage

FILE: src/fsfe_front.sv
`timescale 1ns / 1ps
module fsfe_front #(
  parameter int SW = 256,
  parameter int SH = 128
) (
  input  logic [2:0]          in_cmd,
  input  logic signed [10:0]  in_pos_x,
  input  logic signed [10:0]  in_pos_y,
  input  logic [10:0]         in_width,
  input  logic [10:0]         in_height,
  input  logic [9:0]          in_corner_radius,
  input  logic [9:0]          in_border_thickness,
  input  logic [7:0]          in_draw_color,
  output fsfe_pkg::job_t      job
);

  fsfe_pkg::coord_t px, py, pw, ph, pr, pt;

  assign px = fsfe_pkg::coord_t'(in_pos_x);
  assign py = fsfe_pkg::coord_t'(in_pos_y);
  assign pw = fsfe_pkg::coord_t'({3'b000, in_width});
  assign ph = fsfe_pkg::coord_t'({3'b000, in_height});
  assign pr = fsfe_pkg::coord_t'({4'b0000, in_corner_radius});
  assign pt = fsfe_pkg::coord_t'({4'b0000, in_border_thickness});

  // Every drawing command becomes a rounded shape, filled or outlined;
  // a plain rectangle is one with no radius.
  always_comb begin
    job         = '0;
    job.x       = px;
    job.y       = py;
    job.w       = pw;
    job.h       = ph;
    job.t       = pt;
    job.color   = in_draw_color;
    unique case (fsfe_pkg::cmd_t'(in_cmd))
      fsfe_pkg::CMD_CLEAR: begin
        job.x = '0;
        job.y = '0;
        job.w = fsfe_pkg::coord_t'(SW);
        job.h = fsfe_pkg::coord_t'(SH);
      end
      fsfe_pkg::CMD_SET_PIXEL: begin
        job.w = fsfe_pkg::coord_t'(1);
        job.h = fsfe_pkg::coord_t'(1);
      end
      fsfe_pkg::CMD_GET_PIXEL: begin
        job.is_read = 1'b1;
      end
      fsfe_pkg::CMD_FILL_RECT: begin
      end
      fsfe_pkg::CMD_OUTLINE_RECT: begin
        job.outline = 1'b1;
      end
      fsfe_pkg::CMD_FILL_ROUND: begin
        job.r = pr;
      end
      fsfe_pkg::CMD_OUTLINE_ROUND: begin
        job.r       = pr;
        job.outline = 1'b1;
      end
      fsfe_pkg::CMD_THICK_ROUND: begin
        job.r     = pr;
        job.thick = 1'b1;
        // A zero thickness draws nothing at all.
        if (in_border_thickness == '0) begin
          job.w = '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/fsfe_queue.sv
`timescale 1ns / 1ps
module fsfe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fsfe_pkg::job_t  push_data,
  input  logic            pop,
  output fsfe_pkg::job_t  pop_data,
  output logic            empty,
  output logic            full
);

  fsfe_pkg::job_t slot_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;

  assign empty    = (count_r == 2'd0);
  assign full     = (count_r == 2'd2);
  assign pop_data = slot_r[rd_ptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: src/fsfe_isqrt.sv
`timescale 1ns / 1ps
module fsfe_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [fsfe_pkg::SqInW-1:0]   radicand,
  output logic [fsfe_pkg::SqOutW-1:0]  root,
  output logic                         done
);

  logic [fsfe_pkg::SqInW-1:0]  rad_r;
  logic [fsfe_pkg::SqOutW:0]   rem_r;
  logic [fsfe_pkg::SqOutW-1:0] root_r;
  logic [3:0]                  cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [fsfe_pkg::SqOutW+2:0] rem_sh;
  logic [fsfe_pkg::SqOutW+2:0] trial;
  logic                        fits;

  assign root = root_r;
  assign done = done_r;

  // One result bit per cycle, two radicand bits brought down each time.
  assign rem_sh = {rem_r, rad_r[fsfe_pkg::SqInW-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'(fsfe_pkg::SqOutW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[fsfe_pkg::SqInW-3:0], 2'b00};
      if (fits) begin
        rem_r  <= (fsfe_pkg::SqOutW+1)'(rem_sh - trial);
        root_r <= {root_r[fsfe_pkg::SqOutW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[fsfe_pkg::SqOutW:0];
        root_r <= {root_r[fsfe_pkg::SqOutW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: src/fsfe_back.sv
`timescale 1ns / 1ps
module fsfe_back #(
  parameter int SW = 256,
  parameter int SH = 128
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  fsfe_pkg::job_t  q_data,
  output logic            q_pop,
  input  logic [7:0]      bg_color,
  output logic            out_valid,
  output logic [7:0]      out_pixel_value
);

  localparam int XW = $clog2(SW);
  localparam int YW = $clog2(SH);
  localparam int AW = $clog2(SW * SH);
  localparam fsfe_pkg::coord_t SwC = fsfe_pkg::coord_t'(SW);
  localparam fsfe_pkg::coord_t ShC = fsfe_pkg::coord_t'(SH);
  localparam fsfe_pkg::coord_t One = fsfe_pkg::coord_t'(1);
  localparam fsfe_pkg::coord_t Zero = fsfe_pkg::coord_t'(0);

  fsfe_pkg::back_state_t state_r, state_nxt, ret_r;

  fsfe_pkg::coord_t x_r, y_r, w_r, h_r, r_r, t_r, k_r, dx_r;
  fsfe_pkg::coord_t bx_r, by_r, bw_r, bh_r;
  logic [7:0]       color_r;
  logic             outline_r, thick_r, inb_r;
  logic [2:0]       bi_r;
  logic [XW-1:0]    px_r, x0_r, xl_r;
  logic [YW-1:0]    py_r, yl_r;
  logic [AW-1:0]    rowbase_r;
  logic [7:0]       mem [SW * SH];
  logic [7:0]       rd_data_r;
  logic             out_valid_r;
  logic [7:0]       out_pix_r;

  // Shape geometry.
  fsfe_pkg::coord_t min_wh, half_m, r_clamp, two_r;
  fsfe_pkg::coord_t top_y, bot_y, lft_x, rgt_x, span;
  fsfe_pkg::coord_t sel_x, sel_y, sel_w, sel_h;
  logic [2:0]       n_box;
  logic             shape_empty;
  fsfe_pkg::coord_t iw, ih, ir;

  // Clipping.
  fsfe_pkg::coord_t cx0, cx1, cy0, cy1, cx1m, cy1m;
  logic             box_empty;
  logic             row_end, col_end;

  // Square root feed.
  logic [9:0]                  d_val;
  logic [fsfe_pkg::SqInW-1:0]  rr, dd;
  logic                        sq_start, sq_done;
  logic [fsfe_pkg::SqOutW-1:0] sq_root;

  // Pixel read.
  logic             inb;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             mem_we;

  assign min_wh      = (w_r < h_r) ? w_r : h_r;
  assign half_m      = min_wh >>> 1;
  assign r_clamp     = (r_r > half_m) ? half_m : r_r;
  assign shape_empty = (w_r <= Zero) || (h_r <= Zero);
  assign two_r       = r_r <<< 1;

  assign top_y = y_r + k_r;
  assign bot_y = y_r + h_r - One - k_r;
  assign lft_x = x_r + r_r - dx_r;
  assign rgt_x = x_r + w_r - One - r_r + dx_r;
  assign span  = rgt_x - lft_x + One;

  assign iw = w_r - (t_r <<< 1);
  assign ih = h_r - (t_r <<< 1);
  assign ir = (r_r > t_r) ? (r_r - t_r) : Zero;

  // Box list for the middle band and for each corner row.
  always_comb begin
    sel_x = x_r;
    sel_y = y_r;
    sel_w = w_r;
    sel_h = h_r;
    if (state_r == fsfe_pkg::B_MID) begin
      n_box = outline_r ? 3'd4 : 3'd1;
      if (!outline_r) begin
        if (r_r != Zero) begin
          sel_y = y_r + r_r;
          sel_h = h_r - two_r;
        end
      end else begin
        case (bi_r[1:0])
          2'd0: begin
            sel_x = x_r + r_r;
            sel_w = w_r - two_r;
            sel_h = One;
          end
          2'd1: begin
            sel_x = x_r + r_r;
            sel_y = y_r + h_r - One;
            sel_w = w_r - two_r;
            sel_h = One;
          end
          2'd2: begin
            sel_y = y_r + r_r;
            sel_w = One;
            sel_h = h_r - two_r;
          end
          default: begin
            sel_x = x_r + w_r - One;
            sel_y = y_r + r_r;
            sel_w = One;
            sel_h = h_r - two_r;
          end
        endcase
      end
    end else begin
      n_box = outline_r ? 3'd4 : 3'd2;
      sel_x = lft_x;
      sel_y = bi_r[0] ? bot_y : top_y;
      sel_w = outline_r ? One : span;
      sel_h = One;
      if (outline_r) begin
        sel_x = bi_r[0] ? rgt_x : lft_x;
        sel_y = bi_r[1] ? bot_y : top_y;
      end
    end
  end

  // Clip the latched box to the buffer.
  assign cx0       = (bx_r < Zero) ? Zero : bx_r;
  assign cy0       = (by_r < Zero) ? Zero : by_r;
  assign cx1       = ((bx_r + bw_r) > SwC) ? SwC : (bx_r + bw_r);
  assign cy1       = ((by_r + bh_r) > ShC) ? ShC : (by_r + bh_r);
  assign cx1m      = cx1 - One;
  assign cy1m      = cy1 - One;
  assign box_empty = (bw_r <= Zero) || (bh_r <= Zero) || (cx0 >= cx1) || (cy0 >= cy1);
  assign col_end   = (px_r == xl_r);
  assign row_end   = (py_r == yl_r);

  assign d_val = r_r[9:0] - k_r[9:0];
  assign rr    = r_r[9:0] * r_r[9:0];
  assign dd    = d_val * d_val;

  assign inb = (x_r >= Zero) && (x_r < SwC) && (y_r >= Zero) && (y_r < ShC);
  assign rd_addr = AW'(y_r[YW-1:0]) * AW'(SW) + AW'(x_r[XW-1:0]);
  assign wr_addr = rowbase_r + AW'(px_r);

  fsfe_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (rr - dd),
    .root     (sq_root),
    .done     (sq_done)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsfe_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_nxt = q_data.is_read ? fsfe_pkg::B_READ : fsfe_pkg::B_START;
        end
      end
      fsfe_pkg::B_START: begin
        state_nxt = shape_empty ? fsfe_pkg::B_END : fsfe_pkg::B_MID;
      end
      fsfe_pkg::B_MID: begin
        state_nxt = (bi_r == n_box) ? fsfe_pkg::B_SQ : fsfe_pkg::B_BOXSET;
      end
      fsfe_pkg::B_SQ: begin
        state_nxt = (k_r == r_r) ? fsfe_pkg::B_END : fsfe_pkg::B_SQWAIT;
      end
      fsfe_pkg::B_SQWAIT: begin
        if (sq_done) begin
          state_nxt = fsfe_pkg::B_ROW;
        end
      end
      fsfe_pkg::B_ROW: begin
        state_nxt = (bi_r == n_box) ? fsfe_pkg::B_SQ : fsfe_pkg::B_BOXSET;
      end
      fsfe_pkg::B_BOXSET: begin
        state_nxt = box_empty ? ret_r : fsfe_pkg::B_BOXRUN;
      end
      fsfe_pkg::B_BOXRUN: begin
        if (col_end && row_end) begin
          state_nxt = ret_r;
        end
      end
      fsfe_pkg::B_END: begin
        state_nxt = (thick_r && (iw > Zero) && (ih > Zero)) ?
                    fsfe_pkg::B_START : fsfe_pkg::B_DONE;
      end
      fsfe_pkg::B_READ:  state_nxt = fsfe_pkg::B_RDOUT;
      fsfe_pkg::B_RDOUT: state_nxt = fsfe_pkg::B_IDLE;
      fsfe_pkg::B_DONE:  state_nxt = fsfe_pkg::B_IDLE;
      default:           state_nxt = fsfe_pkg::B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop    = 1'b0;
    sq_start = 1'b0;
    mem_we   = 1'b0;
    unique case (state_r)
      fsfe_pkg::B_IDLE:   q_pop    = !q_empty;
      fsfe_pkg::B_SQ:     sq_start = (k_r != r_r);
      fsfe_pkg::B_BOXRUN: mem_we   = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsfe_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == fsfe_pkg::B_DONE) || (state_r == fsfe_pkg::B_RDOUT);
    end
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk) begin
    out_pix_r <= '0;
    if (state_r == fsfe_pkg::B_RDOUT) begin
      out_pix_r <= inb_r ? rd_data_r : bg_color;
    end
    case (state_r)
      fsfe_pkg::B_IDLE: begin
        x_r       <= q_data.x;
        y_r       <= q_data.y;
        w_r       <= q_data.w;
        h_r       <= q_data.h;
        r_r       <= q_data.r;
        t_r       <= q_data.t;
        color_r   <= q_data.color;
        outline_r <= q_data.outline;
        thick_r   <= q_data.thick;
      end
      fsfe_pkg::B_START: begin
        r_r  <= r_clamp;
        bi_r <= '0;
      end
      fsfe_pkg::B_MID, fsfe_pkg::B_ROW: begin
        if (bi_r == n_box) begin
          if (state_r == fsfe_pkg::B_MID) begin
            k_r <= Zero;
          end else begin
            k_r <= k_r + One;
          end
        end else begin
          bx_r  <= sel_x;
          by_r  <= sel_y;
          bw_r  <= sel_w;
          bh_r  <= sel_h;
          ret_r <= state_r;
        end
      end
      fsfe_pkg::B_SQWAIT: begin
        dx_r <= fsfe_pkg::coord_t'({4'b0000, sq_root});
        bi_r <= '0;
      end
      fsfe_pkg::B_BOXSET: begin
        px_r      <= cx0[XW-1:0];
        x0_r      <= cx0[XW-1:0];
        xl_r      <= cx1m[XW-1:0];
        py_r      <= cy0[YW-1:0];
        yl_r      <= cy1m[YW-1:0];
        rowbase_r <= AW'(cy0[YW-1:0]) * AW'(SW);
        if (box_empty) begin
          bi_r <= bi_r + 3'd1;
        end
      end
      fsfe_pkg::B_BOXRUN: begin
        if (col_end) begin
          px_r      <= x0_r;
          py_r      <= py_r + YW'(1);
          rowbase_r <= rowbase_r + AW'(SW);
          if (row_end) begin
            bi_r <= bi_r + 3'd1;
          end
        end else begin
          px_r <= px_r + XW'(1);
        end
      end
      fsfe_pkg::B_END: begin
        // Carve the inner shape with the background colour.
        thick_r <= 1'b0;
        x_r     <= x_r + t_r;
        y_r     <= y_r + t_r;
        w_r     <= iw;
        h_r     <= ih;
        r_r     <= ir;
        color_r <= bg_color;
      end
      fsfe_pkg::B_READ: begin
        inb_r <= inb;
      end
      default: begin
      end
    endcase
  end

  // Frame store: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= color_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pix_r;

endmodule

FILE: src/framebuffer_shape_fill_engine.sv
`timescale 1ns / 1ps
// On an idle engine a get pixel result appears once its transaction has passed the queue,
// the B_IDLE, B_READ and B_RDOUT states and the output register; a drawing command writes
// one clipped pixel per cycle, plus box setup and corner-row square roots; clear writes SW*SH pixels.
// Throughput is one command at a time in the drawing sequencer; a two-entry queue
// takes new commands while it runs, and busy is high while the queue is full.
// Synchronous active-low reset empties the queue and sets the background to 255.
module framebuffer_shape_fill_engine #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic signed [10:0] in_pos_x,
  input  logic signed [10:0] in_pos_y,
  input  logic [10:0]        in_width,
  input  logic [10:0]        in_height,
  input  logic [9:0]         in_corner_radius,
  input  logic [9:0]         in_border_thickness,
  input  logic [7:0]         in_draw_color,
  output logic               out_valid,
  output logic [7:0]         out_pixel_value,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  fsfe_pkg::job_t job, q_data;
  logic           q_empty, q_full, q_pop;
  logic [7:0]     bg_r;

  // Background colour register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_r <= 8'hFF;
    end else if (cfg_wr_en) begin
      bg_r <= cfg_wr_data;
    end
  end

  assign busy = q_full;

  fsfe_front #(
    .SW (SCREEN_WIDTH),
    .SH (SCREEN_HEIGHT)
  ) u_front (
    .in_cmd              (in_cmd),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_width            (in_width),
    .in_height           (in_height),
    .in_corner_radius    (in_corner_radius),
    .in_border_thickness (in_border_thickness),
    .in_draw_color       (in_draw_color),
    .job                 (job)
  );

  fsfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start && !q_full),
    .push_data (job),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  fsfe_back #(
    .SW (SCREEN_WIDTH),
    .SH (SCREEN_HEIGHT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .bg_color        (bg_r),
    .out_valid       (out_valid),
    .out_pixel_value (out_pixel_value)
  );

endmodule
